FILE: rtl/flow_average_calibrate_alarm_core_defines.svh
// Assertion macros shared by the flow core.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef FLOW_AVERAGE_CALIBRATE_ALARM_CORE_DEFINES_SVH
`define FLOW_AVERAGE_CALIBRATE_ALARM_CORE_DEFINES_SVH

// Same-cycle implication.
`define FACA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FACA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/faca_pkg.sv
`default_nettype none

package faca_pkg;

  localparam int WINDOW_LEN_DEF = 10;

  localparam int CFG_IDX_W = 2;

  localparam logic [15:0] RAW_FAULT_CODE = 16'd256;
  localparam logic [7:0]  RUN_MAX        = 8'd255;

  localparam logic [31:0] COEF_SQUARE_RST = 32'd0;
  localparam logic [31:0] COEF_LINEAR_RST = 32'd65536;
  localparam logic [31:0] COEF_OFFSET_RST = 32'd0;
  localparam logic [7:0]  FAIL_LIMIT_RST  = 8'd40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_SQUARE = 2'd0,
    CFG_COEF_LINEAR = 2'd1,
    CFG_COEF_OFFSET = 2'd2,
    CFG_FAIL_LIMIT  = 2'd3
  } cfg_reg_e;

  // Calibration and alarm settings as seen by the back end.
  typedef struct packed {
    logic [31:0] coef_square;
    logic [31:0] coef_linear;
    logic [31:0] coef_offset;
    logic [7:0]  fail_limit;
  } coef_t;

  // A classified reading waiting in the queue.
  typedef struct packed {
    logic        good;
    logic [15:0] raw;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_ACC,
    BK_DIV,
    BK_MUL1,
    BK_MUL2,
    BK_FIN
  } back_state_e;

endpackage

`default_nettype wire

FILE: rtl/flow_average_calibrate_alarm_core.sv
// Flow reading averager, polynomial calibrator and failure alarm.
// Input channel: in_valid_i with crc_ok_i and raw_flow_i (unsigned Q8.8); the core
// raises in_stall_o when its two-entry reading queue is full. Each transaction
// yields exactly one result on the output channel (out_valid_o, held while
// out_stall_i is high, with the payload steady until the transaction completes).
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i, always ready; write
// only while the core is idle.
// A bad reading (checksum failed, or the fault word 1.0) gives its result in the
// cycle after it leaves the queue; bad readings flow at one per cycle while the
// receiver does not stall. A good reading passes through the back-end states in
// order: a registered window memory read, the running-sum update, a reciprocal
// multiply for the mean, and two multiplier stages for the calibration polynomial;
// the back end takes no new reading until it has finished with the last one.
// When the receiver stalls, the result register holds, the back end waits and
// the queue fills before the input is stalled.
// Reset clears the window (through per-entry valid bits, no clearing pass), the
// running sum, the failure run, the alarm and the held outputs, and loads the
// register defaults.
`default_nettype none

`include "flow_average_calibrate_alarm_core_defines.svh"

module flow_average_calibrate_alarm_core #(
  parameter int WINDOW_LEN = faca_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          crc_ok_i,
  input  wire logic [15:0]                   raw_flow_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               updated_o,
  output logic [15:0]                        averaged_flow_o,
  output logic [31:0]                        calibrated_flow_o,
  output logic [7:0]                         fail_count_o,
  output logic                               alarm_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [faca_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i
);

  faca_pkg::coef_t cfg_q, cfg_d;
  faca_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;

  // The register file never back-pressures; a write takes effect in the cycle after it is presented.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (faca_pkg::cfg_reg_e'(cfg_index_i))
        faca_pkg::CFG_COEF_SQUARE: cfg_d.coef_square = cfg_data_i;
        faca_pkg::CFG_COEF_LINEAR: cfg_d.coef_linear = cfg_data_i;
        faca_pkg::CFG_COEF_OFFSET: cfg_d.coef_offset = cfg_data_i;
        faca_pkg::CFG_FAIL_LIMIT:  cfg_d.fail_limit  = cfg_data_i[7:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_square <= faca_pkg::COEF_SQUARE_RST;
      cfg_q.coef_linear <= faca_pkg::COEF_LINEAR_RST;
      cfg_q.coef_offset <= faca_pkg::COEF_OFFSET_RST;
      cfg_q.fail_limit  <= faca_pkg::FAIL_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The front end classifies each reading as it arrives and queues it.
  faca_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .crc_ok_i   (crc_ok_i),
    .raw_flow_i (raw_flow_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  // The back end owns all reading-to-reading state and the result register.
  faca_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_item_i          (q_item),
    .q_pop_o           (q_pop),
    .cfg_i             (cfg_q),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .updated_o         (updated_o),
    .averaged_flow_o   (averaged_flow_o),
    .calibrated_flow_o (calibrated_flow_o),
    .fail_count_o      (fail_count_o),
    .alarm_o           (alarm_o)
  );

  // The back end must never take a reading from an empty queue.
  `FACA_ASSERT_NOW(a_pop_needs_item, q_pop, q_valid, "queue popped while empty")

  // A refreshed result always reports a cleared failure run and alarm.
  `FACA_ASSERT_NOW(a_good_clears_run, out_valid_o && updated_o,
                   fail_count_o == 8'd0 && !alarm_o, "good result with failure state")

  // The alarm can only be standing after at least one bad reading.
  `FACA_ASSERT_NOW(a_alarm_needs_run, out_valid_o && alarm_o,
                   fail_count_o != 8'd0, "alarm raised with an empty failure run")

endmodule

`default_nettype wire

FILE: rtl/faca_ram.sv
`default_nettype none

module faca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = faca_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/faca_front.sv
`default_nettype none

// Takes readings, marks them good or bad and holds them in a two-entry queue.
module faca_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic            crc_ok_i,
  input  wire logic [15:0]     raw_flow_i,
  output logic                 q_valid_o,
  output faca_pkg::item_t      q_item_o,
  input  wire logic            q_pop_i
);

  faca_pkg::item_t buf_q [2];
  faca_pkg::item_t new_item;
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;

  assign new_item.good = crc_ok_i && (raw_flow_i != faca_pkg::RAW_FAULT_CODE);
  assign new_item.raw  = raw_flow_i;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push    ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/faca_back.sv
`default_nettype none

// Window update, mean, calibration polynomial and failure run, one reading at a time.
module faca_back #(
  parameter int WINDOW_LEN = faca_pkg::WINDOW_LEN_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire faca_pkg::item_t q_item_i,
  output logic                 q_pop_o,
  input  wire faca_pkg::coef_t cfg_i,
  input  wire logic            out_stall_i,
  output logic                 out_valid_o,
  output logic                 updated_o,
  output logic [15:0]          averaged_flow_o,
  output logic [31:0]          calibrated_flow_o,
  output logic [7:0]           fail_count_o,
  output logic                 alarm_o
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int SUM_W  = 16 + SLOT_W;
  localparam int DIV_SH = SUM_W + SLOT_W;
  localparam int DIV_W  = 2 * SUM_W + 1;
  // ceil(2^DIV_SH / WINDOW_LEN) gives an exact quotient for any SUM_W-bit sum.
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << DIV_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [SUM_W:0] RECIP = RECIP_FULL[SUM_W:0];
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
  localparam logic signed [49:0] SAT_HI = 50'sh7FFFFFFF;
  localparam logic signed [49:0] SAT_LO = -50'sh80000000;

  faca_pkg::back_state_e state_q, state_d;

  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [WINDOW_LEN-1:0] vld_q, vld_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [7:0]            run_q, run_d;
  logic                  alarm_q, alarm_d;
  logic [15:0]           held_avg_q, held_avg_d;
  logic [31:0]           held_cal_q, held_cal_d;
  logic                  ovld_q, ovld_d;

  logic [15:0]           raw_q, raw_d;
  logic [DIV_W-1:0]      div_q, div_d;
  logic [31:0]           sq_q, sq_d;
  logic signed [48:0]    lin_q, lin_d;
  logic signed [64:0]    sqt_q, sqt_d;
  logic                  oupd_q, oupd_d;
  logic [15:0]           oavg_q, oavg_d;
  logic [31:0]           ocal_q, ocal_d;
  logic [7:0]            orun_q, orun_d;
  logic                  oalm_q, oalm_d;

  logic                  ram_we;
  logic [15:0]           ram_rdata;
  logic [15:0]           old_val;
  logic                  slot_free;
  logic [15:0]           avg;
  logic [7:0]            run_inc;
  logic                  alarm_bad;
  logic signed [49:0]    t2, t1, off, total;
  logic [31:0]           cal_sat;

  faca_ram #(
    .WIDTH (16),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (raw_q),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  assign slot_free = !ovld_q || !out_stall_i;
  assign old_val   = vld_q[slot_q] ? ram_rdata : 16'd0;
  assign avg       = div_q[DIV_SH +: 16];
  assign run_inc   = (run_q == faca_pkg::RUN_MAX) ? run_q : run_q + 8'd1;
  assign alarm_bad = alarm_q || (run_inc >= cfg_i.fail_limit);

  // Both products are floored to Q16.16 by arithmetic shifts.
  assign t2    = 50'(sqt_q >>> 16);
  assign t1    = 50'(lin_q >>> 8);
  assign off   = 50'($signed(cfg_i.coef_offset));
  assign total = t2 + t1 + off;
  assign cal_sat = (total > SAT_HI) ? 32'h7FFF_FFFF :
                   (total < SAT_LO) ? 32'h8000_0000 : total[31:0];

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    vld_d      = vld_q;
    sum_d      = sum_q;
    run_d      = run_q;
    alarm_d    = alarm_q;
    held_avg_d = held_avg_q;
    held_cal_d = held_cal_q;
    raw_d      = raw_q;
    div_d      = div_q;
    sq_d       = sq_q;
    lin_d      = lin_q;
    sqt_d      = sqt_q;
    ovld_d     = ovld_q && out_stall_i;
    oupd_d     = oupd_q;
    oavg_d     = oavg_q;
    ocal_d     = ocal_q;
    orun_d     = orun_q;
    oalm_d     = oalm_q;
    q_pop_o    = 1'b0;
    ram_we     = 1'b0;

    case (state_q)
      faca_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.good) begin
            q_pop_o = 1'b1;
            raw_d   = q_item_i.raw;
            state_d = faca_pkg::BK_READ;
          end else if (slot_free) begin
            q_pop_o = 1'b1;
            run_d   = run_inc;
            alarm_d = alarm_bad;
            ovld_d  = 1'b1;
            oupd_d  = 1'b0;
            oavg_d  = held_avg_q;
            ocal_d  = held_cal_q;
            orun_d  = run_inc;
            oalm_d  = alarm_bad;
          end
        end
      end
      faca_pkg::BK_READ: begin
        state_d = faca_pkg::BK_ACC;
      end
      faca_pkg::BK_ACC: begin
        ram_we        = 1'b1;
        vld_d[slot_q] = 1'b1;
        sum_d         = sum_q - SUM_W'(old_val) + SUM_W'(raw_q);
        slot_d        = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
        state_d       = faca_pkg::BK_DIV;
      end
      faca_pkg::BK_DIV: begin
        div_d   = DIV_W'(sum_q) * DIV_W'(RECIP);
        state_d = faca_pkg::BK_MUL1;
      end
      faca_pkg::BK_MUL1: begin
        held_avg_d = avg;
        sq_d       = 32'(avg) * 32'(avg);
        lin_d      = $signed(cfg_i.coef_linear) * $signed({1'b0, avg});
        state_d    = faca_pkg::BK_MUL2;
      end
      faca_pkg::BK_MUL2: begin
        sqt_d   = $signed(cfg_i.coef_square) * $signed({1'b0, sq_q});
        state_d = faca_pkg::BK_FIN;
      end
      faca_pkg::BK_FIN: begin
        if (slot_free) begin
          held_cal_d = cal_sat;
          run_d      = 8'd0;
          alarm_d    = 1'b0;
          ovld_d     = 1'b1;
          oupd_d     = 1'b1;
          oavg_d     = held_avg_q;
          ocal_d     = cal_sat;
          orun_d     = 8'd0;
          oalm_d     = 1'b0;
          state_d    = faca_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = faca_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= faca_pkg::BK_IDLE;
      slot_q     <= '0;
      vld_q      <= '0;
      sum_q      <= '0;
      run_q      <= 8'd0;
      alarm_q    <= 1'b0;
      held_avg_q <= 16'd0;
      held_cal_q <= 32'd0;
      ovld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      slot_q     <= slot_d;
      vld_q      <= vld_d;
      sum_q      <= sum_d;
      run_q      <= run_d;
      alarm_q    <= alarm_d;
      held_avg_q <= held_avg_d;
      held_cal_q <= held_cal_d;
      ovld_q     <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q  <= raw_d;
    div_q  <= div_d;
    sq_q   <= sq_d;
    lin_q  <= lin_d;
    sqt_q  <= sqt_d;
    oupd_q <= oupd_d;
    oavg_q <= oavg_d;
    ocal_q <= ocal_d;
    orun_q <= orun_d;
    oalm_q <= oalm_d;
  end

  assign out_valid_o       = ovld_q;
  assign updated_o         = oupd_q;
  assign averaged_flow_o   = oavg_q;
  assign calibrated_flow_o = ocal_q;
  assign fail_count_o      = orun_q;
  assign alarm_o           = oalm_q;

endmodule

`default_nettype wire
